/* sv/psa_pkg.sv */
// Shared constants, types and codes for the pooled bitmap slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;

  // Pool geometry.
  localparam int SLOTS_PER_POOL = 32;
  localparam int BLOCK_TYPES    = 2;
  localparam int SHADER_DOMAINS = 3;
  localparam int POOL_COUNT     = BLOCK_TYPES * SHADER_DOMAINS;

  // Derived widths.
  localparam int POOL_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int SLOT_W = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_POOL + 1);
  localparam int BASE_W = $clog2(SLOTS_PER_POOL * SHADER_DOMAINS + 1);

  // Field widths of the words on the streams.
  localparam int TYPE_W    = 1;
  localparam int DOM_W     = 2;
  localparam int ADDR_W    = 7;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = ((TYPE_W + DOM_W + ADDR_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ADDR_W + 7) / 8) * 8;

  // Configuration port.
  localparam int REG_W     = 6;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = $clog2(4 * POOL_COUNT);
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_W-1:0] COUNT_RESET = REG_W'(16);

  // Operation codes.
  localparam logic FUNC_CAPTURE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef logic [CNT_W-1:0]          count_t;
  typedef logic [SLOTS_PER_POOL-1:0] bitmap_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic commit;
  } psa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } psa_stat_t;

  // One request word as held in the datapath.
  typedef struct packed {
    logic              func;
    logic [TYPE_W-1:0] block_type;
    logic [DOM_W-1:0]  shader_domain;
    addr_t             release_address;
  } req_t;

endpackage
`default_nettype wire

/* sv/psa_regs.sv */
// Slot count registers behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none
module psa_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [psa_pkg::PDATA_W-1:0]  pwdata,
  output logic      [psa_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output psa_pkg::count_t                   counts [psa_pkg::POOL_COUNT]
);
  import psa_pkg::*;

  logic [REG_W-1:0]     cnt_reg [POOL_COUNT];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes; indexes past the last pool are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_COUNT; i++) begin
        cnt_reg[i] <= COUNT_RESET;
      end
    end else if (wr_en) begin
      for (int i = 0; i < POOL_COUNT; i++) begin
        if (reg_idx == REG_IDX_W'(i)) begin
          cnt_reg[i] <= pwdata[REG_W-1:0];
        end
      end
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    for (int i = 0; i < POOL_COUNT; i++) begin
      if (reg_idx == REG_IDX_W'(i)) begin
        prdata = PDATA_W'(cnt_reg[i]);
      end
    end
  end

  // Counts above the pool size act as the pool size.
  always_comb begin
    for (int i = 0; i < POOL_COUNT; i++) begin
      if (cnt_reg[i] > SLOTS_PER_POOL) begin
        counts[i] = CNT_W'(SLOTS_PER_POOL);
      end else begin
        counts[i] = CNT_W'(cnt_reg[i]);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/psa_ctrl.sv */
// Controller state machine that sequences one request at a time.
`timescale 1ns / 1ps
`default_nettype none
module psa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire psa_pkg::psa_stat_t stat,
  output psa_pkg::psa_cmd_t       cmd
);
  import psa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready     = (state == S_IDLE);
  assign cmd.load_req = s_tvalid & s_tready;
  assign cmd.commit   = (state == S_EXEC) & stat.out_free;

  // Next state: take a word, then commit it once the output register is free.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load_req) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* sv/psa_dp.sv */
// Datapath: request register, occupancy bitmaps, first-free search, output register.
`timescale 1ns / 1ps
`default_nettype none
module psa_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire psa_pkg::psa_cmd_t              cmd,
  output psa_pkg::psa_stat_t                  stat,
  input  wire logic [psa_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic                           s_tuser,
  input  wire psa_pkg::count_t                counts [psa_pkg::POOL_COUNT],
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [psa_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic      [psa_pkg::STATUS_W-1:0]   m_tuser
);
  import psa_pkg::*;

  localparam int OFF_W = (BASE_W > ADDR_W) ? BASE_W : ADDR_W;

  req_t              req;
  bitmap_t           bitmaps [POOL_COUNT];
  logic              pool_ok;
  logic [POOL_W-1:0] pool_idx;
  bitmap_t           cur_bm;
  count_t            cur_cnt;
  logic [BASE_W-1:0] base;
  bitmap_t           free_mask;
  bitmap_t           lowest;
  logic              found;
  logic [SLOT_W-1:0] slot_idx;
  logic [BASE_W:0]   grant_sum;
  logic [OFF_W-1:0]  rel_diff;
  logic              rel_hit;
  logic [SLOT_W-1:0] rel_slot;
  bitmap_t           new_bm;
  status_t           res_status;
  addr_t             res_granted;
  logic              out_valid;
  status_t           out_status;
  addr_t             out_granted;

  // Request register, loaded when a word is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req.func            <= s_tuser;
      req.block_type      <= s_tdata[TYPE_W-1:0];
      req.shader_domain   <= s_tdata[TYPE_W+DOM_W-1:TYPE_W];
      req.release_address <= s_tdata[TYPE_W+DOM_W+ADDR_W-1:TYPE_W+DOM_W];
    end
  end

  // Pool lookup: bitmap, clamped count and base of the addressed pool.
  always_comb begin
    pool_ok  = (req.block_type < BLOCK_TYPES) && (req.shader_domain < SHADER_DOMAINS);
    pool_idx = POOL_W'(int'(req.block_type) * SHADER_DOMAINS + int'(req.shader_domain));
    cur_bm   = '0;
    cur_cnt  = '0;
    for (int p = 0; p < POOL_COUNT; p++) begin
      if (pool_ok && pool_idx == POOL_W'(p)) begin
        cur_bm  = bitmaps[p];
        cur_cnt = counts[p];
      end
    end
    base = '0;
    for (int t = 0; t < BLOCK_TYPES; t++) begin
      for (int d = 0; d < SHADER_DOMAINS; d++) begin
        if (req.block_type == TYPE_W'(t) && d < int'(req.shader_domain)) begin
          base = base + BASE_W'(counts[t * SHADER_DOMAINS + d]);
        end
      end
    end
  end

  // First free slot below the count: isolate the lowest set bit, then encode it.
  always_comb begin
    for (int i = 0; i < SLOTS_PER_POOL; i++) begin
      free_mask[i] = ~cur_bm[i] & (i < int'(cur_cnt));
    end
    lowest   = free_mask & (~free_mask + bitmap_t'(1));
    found    = |free_mask;
    slot_idx = '0;
    for (int i = 0; i < SLOTS_PER_POOL; i++) begin
      if (lowest[i]) slot_idx = slot_idx | SLOT_W'(i);
    end
    grant_sum = {1'b0, base} + (BASE_W + 1)'(slot_idx);
  end

  // Release bounds check against the pool's extent.
  always_comb begin
    rel_diff = OFF_W'(req.release_address) - OFF_W'(base);
    rel_hit  = pool_ok && (OFF_W'(req.release_address) >= OFF_W'(base)) &&
               (rel_diff < OFF_W'(cur_cnt));
    rel_slot = rel_diff[SLOT_W-1:0];
  end

  // Result and bitmap update of the pending request.
  always_comb begin
    new_bm      = cur_bm;
    res_granted = '0;
    if (req.func == FUNC_CAPTURE) begin
      if (pool_ok && found) begin
        res_status  = ST_DONE;
        res_granted = ADDR_W'(grant_sum);
        new_bm      = cur_bm | lowest;
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      if (rel_hit) begin
        res_status = ST_DONE;
        new_bm     = cur_bm & ~(bitmap_t'(1) << rel_slot);
      end else begin
        res_status = ST_OUTSIDE;
      end
    end
  end

  // Occupancy bitmaps, all slots free after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        bitmaps[p] <= '0;
      end
    end else if (cmd.commit && pool_ok) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        if (pool_idx == POOL_W'(p)) bitmaps[p] <= new_bm;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status  <= res_status;
      out_granted <= res_granted;
    end
  end

  assign stat.out_free = ~out_valid | m_tready;
  assign m_tvalid      = out_valid;
  assign m_tdata       = M_TDATA_W'(out_granted);
  assign m_tuser       = out_status;

endmodule
`default_nettype wire

/* sv/pooled_bitmap_slot_allocator.sv */
// Top level of the pooled bitmap slot allocator.
//
// Six slot pools (uniform and storage blocks, each for the vertex, geometry and
// fragment domains) each keep a 32-bit occupancy bitmap. A request word on the
// slave stream either captures the lowest free slot of a pool and returns its
// binding address (pool base plus slot), or releases the slot at a given address.
// The master stream returns one word per request: status in tuser, the granted
// address in tdata.
// Slot counts are set through the APB-style port, one register per pool at byte
// address 4*i; writes are meant to happen while no request is pending.
// Flow: a word is accepted in the idle state, the search and bitmap update run in
// the execute state, and the result enters the output register once it is free.
// The sequencer holds one request at a time, so no new word is taken before the
// last one is committed; the limit is the shared search and update stage.
// If the receiver stalls, the result waits in the output register, one more word
// can still be accepted, and it is held until the register frees.
// Reset clears all bitmaps, sets every count to 16 and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module pooled_bitmap_slot_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Request stream.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [0] block_type, [2:1] shader_domain, [9:3] release_address, rest zero
  input  wire logic [psa_pkg::S_TDATA_W-1:0]  s_tdata,
  // [0] func
  input  wire logic                           s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [6:0] granted_address, rest zero
  output logic      [psa_pkg::M_TDATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic      [psa_pkg::STATUS_W-1:0]   m_tuser,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [psa_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [psa_pkg::PDATA_W-1:0]    pwdata,
  output logic      [psa_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);
  import psa_pkg::*;

  psa_cmd_t  cmd;
  psa_stat_t stat;
  count_t    counts [POOL_COUNT];

  psa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .counts  (counts)
  );

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .counts   (counts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

/* sv/psa_checker.sv */
// Port-level checks on the slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module psa_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [psa_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire logic [psa_pkg::STATUS_W-1:0]   m_tuser
);
  import psa_pkg::*;

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE || m_tuser == ST_FULL || m_tuser == ST_OUTSIDE))
    else $error("undefined status code");

  // A failed capture or release never carries a granted address.
  a_zero_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_DONE |-> m_tdata == '0)
    else $error("address given with a failing status");

  // One request at a time: no second word right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is pending");

  // The output is empty in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result word present after reset");

endmodule

bind pooled_bitmap_slot_allocator psa_checker u_psa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/pooled_bitmap_slot_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the pooled bitmap slot allocator.
module pooled_bitmap_slot_allocator_tb;
  import psa_pkg::*;

  // Field codes used when building request words.
  localparam logic TYPE_UNIFORM = 1'b0;
  localparam logic TYPE_STORAGE = 1'b1;
  localparam logic [DOM_W-1:0] DOM_VERTEX   = 2'd0;
  localparam logic [DOM_W-1:0] DOM_GEOMETRY = 2'd1;
  localparam logic [DOM_W-1:0] DOM_FRAGMENT = 2'd2;
  localparam logic [DOM_W-1:0] DOM_NONE     = 2'd3;

  // Count register indexes; index POOL_COUNT and up hold no register.
  localparam int REG_UNIFORM_VERTEX   = 0;
  localparam int REG_UNIFORM_GEOMETRY = 1;
  localparam int REG_UNIFORM_FRAGMENT = 2;
  localparam int REG_STORAGE_VERTEX   = 3;
  localparam int REG_STORAGE_GEOMETRY = 4;
  localparam int REG_STORAGE_FRAGMENT = 5;
  localparam int REG_PAST_END         = POOL_COUNT;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 100;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    status_t status;
    addr_t   granted;
  } grant_t;

  // Tracks pool occupancy and counts, and holds the grants still owed.
  class slot_ledger;
    bitmap_t          busy [POOL_COUNT];
    logic [REG_W-1:0] count_reg [POOL_COUNT];
    grant_t           owed_q [$];
    int errors, checked, captures, releases, fulls, outsides;

    function new();
      foreach (busy[p]) begin
        busy[p]      = '0;
        count_reg[p] = COUNT_RESET;
      end
    endfunction

    function void set_count(int idx, logic [REG_W-1:0] v);
      if (idx < POOL_COUNT) count_reg[idx] = v;
    endfunction

    function int slots_of(int pool);
      return (count_reg[pool] > SLOTS_PER_POOL) ? SLOTS_PER_POOL : int'(count_reg[pool]);
    endfunction

    // A pool starts after the lower domains of the same block type.
    function int base_of(int t, int d);
      int sum;
      sum = 0;
      for (int k = 0; k < d; k++) sum += slots_of(t * SHADER_DOMAINS + k);
      return sum;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Applies one accepted request and records the word it must produce.
    function void note_request(logic f, logic t, logic [DOM_W-1:0] d, addr_t a);
      grant_t g;
      int pool, n, b, ai;
      g.status  = ST_FULL;
      g.granted = '0;
      ai = int'(a);
      if (f == FUNC_RELEASE) releases++;
      else captures++;
      if (d >= SHADER_DOMAINS) begin
        g.status = (f == FUNC_RELEASE) ? ST_OUTSIDE : ST_FULL;
      end else begin
        pool = int'(t) * SHADER_DOMAINS + int'(d);
        n    = slots_of(pool);
        b    = base_of(t, d);
        if (f == FUNC_CAPTURE) begin
          for (int i = 0; i < n; i++) begin
            if (!busy[pool][i]) begin
              busy[pool][i] = 1'b1;
              g.granted     = addr_t'(b + i);
              g.status      = ST_DONE;
              break;
            end
          end
        end else if (ai >= b && ai - b < n) begin
          busy[pool][ai - b] = 1'b0;
          g.status           = ST_DONE;
        end else begin
          g.status = ST_OUTSIDE;
        end
      end
      if (g.status == ST_FULL) fulls++;
      if (g.status == ST_OUTSIDE) outsides++;
      owed_q.push_back(g);
    endfunction

    // Compares one result word against the oldest grant owed.
    function void check_result(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] data);
      grant_t g;
      if (owed_q.size() == 0) begin
        $error("result word with no request outstanding: status %0d, granted_address %0d",
               st, data);
        errors++;
        return;
      end
      g = owed_q.pop_front();
      checked++;
      if (st !== g.status) begin
        $error("status: expected %0d, got %0d", g.status, st);
        errors++;
      end
      if (data !== M_TDATA_W'(g.granted)) begin
        $error("granted_address: expected %0d, got %0d", g.granted, data);
        errors++;
      end
    endfunction

    // Returns the address of a random slot in use, or -1 if there is none.
    function int used_address(logic t, logic [DOM_W-1:0] d);
      int pool, n, start, s;
      if (d >= SHADER_DOMAINS) return -1;
      pool = int'(t) * SHADER_DOMAINS + int'(d);
      n    = slots_of(pool);
      if (n == 0) return -1;
      start = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
        s = (start + i) % n;
        if (busy[pool][s]) return base_of(t, d) + s;
      end
      return -1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_W-1:0]    paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  slot_ledger ledger = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 30;
  int hold_left     = 0;
  int settings_seen = 0;

  pooled_bitmap_slot_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check each accepted word, then pick the next tready.
  // A requested hold-off keeps tready low while hold_left counts down.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_result(m_tuser, m_tdata);
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one request word after a random gap and waits until it is taken.
  task automatic send_request(logic f, logic t, logic [DOM_W-1:0] d, addr_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= S_TDATA_W'({a, d, t});
    do @(posedge clk); while (!s_tready);
    ledger.note_request(f, t, d, a);
  endtask

  // Mostly captures and releases of slots in use, plus near misses and noise.
  task automatic send_random_request();
    logic f, t;
    logic [DOM_W-1:0] d;
    addr_t a;
    int roll, used, b, n;
    t    = 1'($urandom_range(1));
    d    = ($urandom_range(99) < 6) ? DOM_NONE : DOM_W'($urandom_range(2));
    a    = addr_t'($urandom_range(127));
    roll = $urandom_range(99);
    f    = FUNC_CAPTURE;
    if (roll >= 48) begin
      f    = FUNC_RELEASE;
      used = ledger.used_address(t, d);
      if (roll < 80 && used >= 0) begin
        a = addr_t'(used);
      end else if (roll < 92 && d != DOM_NONE) begin
        b = ledger.base_of(t, d);
        n = ledger.slots_of(int'(t) * SHADER_DOMAINS + int'(d));
        a = addr_t'(b - 1 + $urandom_range(n + 1));
      end
    end
    send_request(f, t, d, a);
  endtask

  // Waits until every owed result has come back and the block is quiet.
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (ledger.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (ledger.pending() != 0) begin
      $error("%0d expected result words never arrived", ledger.pending());
      ledger.errors++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes one count register, then reads it back.
  task automatic write_count(int idx, logic [REG_W-1:0] v);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[REG_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_count(idx, v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < POOL_COUNT && prdata !== PDATA_W'(v)) begin
      $error("prdata of register %0d: expected %0d, got %0d", idx, v, prdata);
      ledger.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Count setting of one register in a given random phase.
  function automatic logic [REG_W-1:0] phase_count(int phase, int r);
    case (phase)
      0:       return REG_W'(SLOTS_PER_POOL);
      1, 4:    return REG_W'($urandom_range(63));
      2:       return REG_W'($urandom_range(3));
      3:       return (r % 3 == 1) ? '0 : REG_W'(63);
      default: return REG_W'($urandom_range(8, 1));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset counts: one capture per pool, missing domain, and release corners.
    settings_seen++;
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_VERTEX, '0);
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_GEOMETRY, '0);
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_FRAGMENT, '0);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_VERTEX, '0);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_GEOMETRY, '0);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_FRAGMENT, '0);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_NONE, '0);
    send_request(FUNC_RELEASE, TYPE_STORAGE, DOM_NONE, '0);
    send_request(FUNC_RELEASE, TYPE_UNIFORM, DOM_GEOMETRY, 7'd16);
    // Releasing a slot that is already free still succeeds.
    send_request(FUNC_RELEASE, TYPE_UNIFORM, DOM_GEOMETRY, 7'd16);
    send_request(FUNC_RELEASE, TYPE_UNIFORM, DOM_GEOMETRY, 7'd15);
    send_request(FUNC_RELEASE, TYPE_STORAGE, DOM_FRAGMENT, 7'd127);
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_GEOMETRY, 7'd127);
    drain();

    // Shrink, empty and oversize pools while earlier slots are still held.
    write_count(REG_UNIFORM_VERTEX, 6'd1);
    write_count(REG_UNIFORM_GEOMETRY, 6'd0);
    write_count(REG_UNIFORM_FRAGMENT, 6'd32);
    write_count(REG_STORAGE_VERTEX, 6'd63);
    write_count(REG_STORAGE_GEOMETRY, 6'd32);
    write_count(REG_STORAGE_FRAGMENT, 6'd1);
    write_count(REG_PAST_END, 6'd0);
    write_count(REG_PAST_END + 1, 6'd63);
    settings_seen++;
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_VERTEX, '0);
    send_request(FUNC_RELEASE, TYPE_UNIFORM, DOM_VERTEX, 7'd0);
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_VERTEX, '0);
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_GEOMETRY, '0);
    send_request(FUNC_RELEASE, TYPE_UNIFORM, DOM_GEOMETRY, 7'd1);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_FRAGMENT, '0);
    send_request(FUNC_RELEASE, TYPE_STORAGE, DOM_FRAGMENT, 7'd64);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_FRAGMENT, '0);
    send_request(FUNC_CAPTURE, TYPE_STORAGE, DOM_GEOMETRY, '0);
    send_request(FUNC_RELEASE, TYPE_STORAGE, DOM_GEOMETRY, 7'd63);
    send_request(FUNC_CAPTURE, TYPE_UNIFORM, DOM_FRAGMENT, '0);
    drain();

    // Random phases, each with fresh counts and its own idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int r = 0; r < POOL_COUNT; r++) write_count(r, phase_count(p, r));
      settings_seen++;
      // Long receiver stall while the sender keeps offering words.
      if (p == 4) hold_left = HOLD_CYCLES;
      repeat (PHASE_WORDS) send_random_request();
      drain();
    end

    $display("Ran %0d requests (%0d captures, %0d releases) over %0d count settings.",
             ledger.captures + ledger.releases, ledger.captures, ledger.releases,
             settings_seen);
    $display("Checked %0d result words, %0d pool-full and %0d out-of-range replies.",
             ledger.checked, ledger.fulls, ledger.outsides);
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $error("timeout waiting on a handshake");
    $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
sv/psa_pkg.sv
sv/psa_regs.sv
sv/psa_ctrl.sv
sv/psa_dp.sv
sv/pooled_bitmap_slot_allocator.sv
sv/psa_checker.sv
tb/pooled_bitmap_slot_allocator_tb.sv
